// ----- design/luhn_pkg.sv -----
package luhn_pkg;

	localparam int unsigned NumWidth   = 63;
	localparam int unsigned BcdDigits  = 20;
	localparam int unsigned BcdWidth   = 4 * BcdDigits;
	localparam int unsigned CntWidth   = 6;
	localparam int unsigned StepWidth  = 2;

	// microcode loop lengths (counter runs init..0)
	localparam logic [CntWidth-1:0] DabbleInit = CntWidth'(NumWidth - 1);
	localparam logic [CntWidth-1:0] ScanInit   = CntWidth'(BcdDigits / 2 - 1);

	localparam logic [4:0] LenShortA = 5'd13;
	localparam logic [4:0] LenB      = 5'd15;
	localparam logic [4:0] LenLong   = 5'd16;

	localparam logic [3:0] DigitFour  = 4'd4;
	localparam logic [3:0] DigitThree = 4'd3;
	localparam logic [3:0] DigitSeven = 4'd7;
	localparam logic [3:0] DigitFive  = 4'd5;
	localparam logic [3:0] DigitOne   = 4'd1;

	typedef enum logic [1:0] {
		TYPE_INVALID = 2'd0,
		TYPE_B       = 2'd1,
		TYPE_C       = 2'd2,
		TYPE_A       = 2'd3
	} card_type_t;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_DABBLE,
		OP_SCAN,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		C_NO_REQ,
		C_CNT_NZ,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t                 op;
		cond_t               cond;
		logic [StepWidth-1:0] target;
		logic                load_cnt;
		logic [CntWidth-1:0]  cnt_init;
	} uword_t;

	localparam logic [StepWidth-1:0] StepLoad   = 2'd0;
	localparam logic [StepWidth-1:0] StepDabble = 2'd1;
	localparam logic [StepWidth-1:0] StepScan   = 2'd2;
	localparam logic [StepWidth-1:0] StepEmit   = 2'd3;

	// control store: jump to target while cond holds, else fall through
	// (the last step wraps to the first); cnt loads on fall through where load_cnt is set
	function automatic uword_t ucode(input logic [StepWidth-1:0] step);
		uword_t w;
		unique case (step)
			StepLoad:   w = '{OP_LOAD,   C_NO_REQ,   StepLoad,   1'b1, DabbleInit};
			StepDabble: w = '{OP_DABBLE, C_CNT_NZ,   StepDabble, 1'b1, ScanInit};
			StepScan:   w = '{OP_SCAN,   C_CNT_NZ,   StepScan,   1'b0, '0};
			StepEmit:   w = '{OP_EMIT,   C_OUT_FULL, StepEmit,   1'b0, '0};
			default:    w = '{OP_LOAD,   C_NO_REQ,   StepLoad,   1'b1, DabbleInit};
		endcase
		return w;
	endfunction

endpackage

// ----- design/luhn_card_number_classifier.sv -----
// Luhn card number classifier.
// Request channel: card_valid / card_ready carry a 63-bit binary card number.
// Result channel: result_valid / result_ready carry card_type, digit_count
// and checksum_ok, one result per request.
// A four-step microprogram drives the datapath: a load step, 63 iterations
// of a double-dabble step that turns the number into 20 BCD digits, 10 scan
// iterations that consume two digits each (Luhn sum mod 10, digit count,
// leading digits), and an emit step that writes the output register.
// Requests are taken one at a time: card_ready is high only in the load step,
// so the bit-serial BCD loop and the two-digit scan loop of one request
// finish before the next request is accepted.
// The output register holds a result until it is taken; meanwhile the next
// request is accepted and converted, and the emit step waits for the output
// register to free up if the receiver stalls.
// Reset (arst_n low) returns the sequencer to the load step and drops
// result_valid.
module luhn_card_number_classifier
	import luhn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                card_valid,
	output logic                card_ready,
	input  logic [NumWidth-1:0] card_number,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [1:0]          card_type,
	output logic [4:0]          digit_count,
	output logic                checksum_ok
);

	logic [StepWidth-1:0] step_q, step_d;
	logic [CntWidth-1:0]  cnt_q;
	uword_t               uw;
	logic                 take;

	logic [NumWidth-1:0]  bin_q;
	logic [BcdWidth-1:0]  bcd_q;
	logic [BcdWidth-1:0]  bcd_adj;

	logic [3:0] sum_q;
	logic [4:0] count_q;
	logic [3:0] top_q, second_q, prev_d1_q;
	logic [3:0] pidx_q;

	logic [3:0] d0, d1, dbl;
	logic [4:0] acc, acc_mod;
	logic [1:0] kind;

	logic       result_valid_q;
	logic [1:0] card_type_q;
	logic [4:0] digit_count_q;
	logic       checksum_ok_q;

	assign uw = ucode(step_q);

	always_comb begin
		unique case (uw.cond)
			C_NO_REQ:   take = !card_valid;
			C_CNT_NZ:   take = (cnt_q != '0);
			C_OUT_FULL: take = result_valid_q && !result_ready;
			default:    take = 1'b0;
		endcase
		step_d = take ? uw.target : step_q + StepWidth'(1);
	end

	assign card_ready = (uw.op == OP_LOAD);

	// double dabble: add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < BcdDigits; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                              : bcd_q[i*4 +: 4];
		end
	end

	// scan datapath: d0 at even position, d1 at odd position (doubled)
	always_comb begin
		d0      = bcd_q[3:0];
		d1      = bcd_q[7:4];
		dbl     = (d1 < 4'd5) ? {d1[2:0], 1'b0} : 4'({d1, 1'b0} - 5'd9);
		acc     = 5'(sum_q) + 5'(d0) + 5'(dbl);
		if (acc >= 5'd20)
			acc_mod = acc - 5'd20;
		else if (acc >= 5'd10)
			acc_mod = acc - 5'd10;
		else
			acc_mod = acc;
	end

	always_comb begin
		kind = TYPE_INVALID;
		if (sum_q == 4'd0) begin
			if (count_q == LenShortA) begin
				if (top_q == DigitFour)
					kind = TYPE_A;
			end else if (count_q == LenB) begin
				if (top_q == DigitThree && (second_q == DigitFour || second_q == DigitSeven))
					kind = TYPE_B;
			end else if (count_q == LenLong) begin
				if (top_q == DigitFour)
					kind = TYPE_A;
				else if (top_q == DigitFive && second_q >= DigitOne && second_q <= DigitFive)
					kind = TYPE_C;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= StepLoad;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (!take && uw.load_cnt)
				cnt_q <= uw.cnt_init;
			else if (take && uw.cond == C_CNT_NZ)
				cnt_q <= cnt_q - CntWidth'(1);
			if (uw.op == OP_EMIT && !take)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_LOAD: begin
				if (card_valid) begin
					bin_q     <= card_number;
					bcd_q     <= '0;
					sum_q     <= '0;
					count_q   <= '0;
					top_q     <= '0;
					second_q  <= '0;
					prev_d1_q <= '0;
					pidx_q    <= '0;
				end
			end
			OP_DABBLE: begin
				{bcd_q, bin_q} <= {bcd_adj[BcdWidth-2:0], bin_q, 1'b0};
			end
			OP_SCAN: begin
				sum_q <= acc_mod[3:0];
				if (d1 != 4'd0) begin
					count_q  <= {pidx_q, 1'b0} + 5'd2;
					top_q    <= d1;
					second_q <= d0;
				end else if (d0 != 4'd0) begin
					count_q  <= {pidx_q, 1'b0} + 5'd1;
					top_q    <= d0;
					second_q <= prev_d1_q;
				end
				prev_d1_q <= d1;
				pidx_q    <= pidx_q + 4'd1;
				bcd_q     <= {8'd0, bcd_q[BcdWidth-1:8]};
			end
			OP_EMIT: begin
				if (!take) begin
					card_type_q   <= kind;
					digit_count_q <= count_q;
					checksum_ok_q <= (sum_q == 4'd0);
				end
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign card_type    = card_type_q;
	assign digit_count  = digit_count_q;
	assign checksum_ok  = checksum_ok_q;

endmodule
